// File: sv/swm_pkg.sv
// Shared constants, types and sequencer codes for the running median filter.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_SIZE = 19;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

  localparam logic [DATA_W-1:0] RESET_TIME  = DATA_W'(100000);
  localparam logic [CNT_W-1:0]  MEDIAN_RANK = CNT_W'((WINDOW_SIZE + 1) / 2);
  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(WINDOW_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } swm_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;     // write the new sample, restart the candidate scan
    logic issue;    // compare the current candidate against the window
    logic capture;  // latch the checked candidate as the result
  } swm_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic hit;      // checked candidate holds the median rank
    logic last;     // candidate index is at the last slot
  } swm_stat_t;

endpackage

// File: sv/sliding_window_median.sv
// Top level of the 19-entry running median filter.
//
// Input channel: sample_time with in_valid / in_stall. A sample is taken at
// a rising edge where in_valid is high and in_stall is low. It overwrites
// the oldest of the WINDOW_SIZE window entries.
// Output channel: median_value with out_valid / out_stall. One item comes
// out per sample: the median of the window after the write, counting
// equal entries once each toward the rank.
// Scan: one candidate entry is ranked per cycle against the whole window
// (a compare stage and a count-and-check stage, overlapped), so the time
// until out_valid rises depends on where the first entry that holds the
// median rank sits.
// Flow: one item at a time; in_stall stays high from acceptance until the
// result is taken.
// Reset (rst, synchronous): every window entry goes to 100000 us, the write
// pointer to slot 0, and both channels go idle.
// Receiver stall: the result and out_valid hold until out_stall drops; no
// new sample is taken meanwhile.
`timescale 1ns / 1ps

module sliding_window_median (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [swm_pkg::DATA_W-1:0] sample_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [swm_pkg::DATA_W-1:0] median_value
);
  import swm_pkg::*;

  swm_cmd_t  cmd;
  swm_stat_t stat;

  // Sequencer: owns both handshakes, steps the candidate scan.
  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: window store, parallel compares, rank check, result register.
  swm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample_time  (sample_time),
    .cmd          (cmd),
    .stat         (stat),
    .median_value (median_value)
  );

endmodule

// File: sv/swm_ctrl.sv
// Sequencer for the running median filter: handshakes and scan control.
`timescale 1ns / 1ps

module swm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  swm_pkg::swm_stat_t stat,
  output swm_pkg::swm_cmd_t  cmd
);
  import swm_pkg::*;

  swm_state_t state;
  swm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.hit) state_next = ST_DONE;
        else if (stat.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.issue   = 1'b1;
        cmd.capture = stat.hit;
      end
      ST_DRAIN: begin
        // The last candidate is the only one left, so it holds the rank.
        cmd.capture = 1'b1;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: sv/swm_datapath.sv
// Window store, candidate compare stage and rank check for the median filter.
`timescale 1ns / 1ps

module swm_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [swm_pkg::DATA_W-1:0] sample_time,
  input  swm_pkg::swm_cmd_t          cmd,
  output swm_pkg::swm_stat_t         stat,
  output logic [swm_pkg::DATA_W-1:0] median_value
);
  import swm_pkg::*;

  logic [DATA_W-1:0]      window [WINDOW_SIZE];
  logic [IDX_W-1:0]       wr_slot;
  logic [IDX_W-1:0]       idx;
  logic [WINDOW_SIZE-1:0] lt_vec;
  logic [WINDOW_SIZE-1:0] le_vec;
  logic [WINDOW_SIZE-1:0] lt_reg;
  logic [WINDOW_SIZE-1:0] le_reg;
  logic [DATA_W-1:0]      cand;
  logic [DATA_W-1:0]      cand_reg;
  logic                   chk_valid;
  logic [CNT_W-1:0]       below;
  logic [CNT_W-1:0]       at_or_below;

  assign cand = window[idx];

  always_comb begin
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      lt_vec[j] = window[j] <  cand;
      le_vec[j] = window[j] <= cand;
    end
  end

  assign below       = CNT_W'($countones(lt_reg));
  assign at_or_below = CNT_W'($countones(le_reg));

  assign stat.hit  = chk_valid && (below < MEDIAN_RANK) && (MEDIAN_RANK <= at_or_below);
  assign stat.last = (idx == LAST_IDX);

  // Window and write pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WINDOW_SIZE; j++) window[j] <= RESET_TIME;
      wr_slot <= '0;
    end else if (cmd.load) begin
      window[wr_slot] <= sample_time;
      wr_slot         <= (wr_slot == LAST_IDX) ? '0 : wr_slot + 1'b1;
    end
  end

  // Candidate index and check-stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      chk_valid <= 1'b0;
    end else if (cmd.load) begin
      idx       <= '0;
      chk_valid <= 1'b0;
    end else if (cmd.issue) begin
      if (idx != LAST_IDX) idx <= idx + 1'b1;
      chk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      lt_reg   <= lt_vec;
      le_reg   <= le_vec;
      cand_reg <= cand;
    end
    if (cmd.capture) begin
      median_value <= cand_reg;
    end
  end

endmodule

// File: sv/swm_checker.sv
// Port-level checks for the running median filter, bound to the top level.
`timescale 1ns / 1ps

module swm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [swm_pkg::DATA_W-1:0] sample_time,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [swm_pkg::DATA_W-1:0] median_value
);

  // Hold a stalled sample until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(sample_time))
    else $error("stalled sample changed");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median_value))
    else $error("stalled result changed");

  // Block new samples right after one is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sample taken while previous one in flight");

  // Never take a sample while a result waits.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // Drop the output after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

// File: sim/sliding_window_median_tb.sv
// Self-checking testbench for the 19-entry running median filter.
`timescale 1ns / 1ps

module sliding_window_median_tb;

  import swm_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int PAUSE_AT     = 650;
  // Slowest correct item: sender gap + full candidate scan + receiver stall.
  // The limit stays far above what all 1352 items need.
  localparam int LIMIT_NS     = 2_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [DATA_W-1:0] sample_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] median_value;

  sliding_window_median dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_time  (sample_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_value (median_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(LIMIT_NS);
    $display("sliding_window_median_tb failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Median predictor: own copy of the window and its write pointer.
  // ------------------------------------------------------------------
  logic [DATA_W-1:0] shadow_window [WINDOW_SIZE];
  int                shadow_slot;
  logic [DATA_W-1:0] median_expected_q [$];
  int                fault_count = 0;

  // Overwrite the oldest entry, advance the pointer, then rank each entry in
  // turn: the median is the first entry x with fewer than MEDIAN_RANK
  // entries below it and at least MEDIAN_RANK entries at or below it.
  function automatic logic [DATA_W-1:0] insert_and_rank(input logic [DATA_W-1:0] s);
    int below;
    int at_or_below;
    shadow_window[shadow_slot] = s;
    shadow_slot = (shadow_slot == WINDOW_SIZE - 1) ? 0 : shadow_slot + 1;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      below       = 0;
      at_or_below = 0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        if (shadow_window[j] < shadow_window[i]) below++;
        if (shadow_window[j] <= shadow_window[i]) at_or_below++;
      end
      if (below < int'(MEDIAN_RANK) && int'(MEDIAN_RANK) <= at_or_below)
        return shadow_window[i];
    end
    return shadow_window[0];
  endfunction

  // ------------------------------------------------------------------
  // Directed table. Rows with a typed median check the block directly;
  // the rest take the predictor's value. The first rows land in a window
  // still full of the 100000 us reset value, so the median cannot move.
  // ------------------------------------------------------------------
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              known;
    logic [DATA_W-1:0] median;
  } probe_row_t;

  localparam int PROBE_ROWS = 22;

  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{32'h0000_0000, 1'b1, 32'd100000},  // zero into a reset window
    '{32'hFFFF_FFFF, 1'b1, 32'd100000},  // all ones
    '{32'd100000,    1'b1, 32'd100000},  // same as the reset value
    '{32'h0000_0001, 1'b0, 32'h0},
    '{32'hFFFF_FFFE, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 32'h0},       // top bit alone
    '{32'h7FFF_FFFF, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 32'h0},       // duplicates of the extremes
    '{32'h0000_0000, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'd100001,    1'b0, 32'h0},       // straddle the reset value
    '{32'd99999,     1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 32'h0},       // a run of equal entries
    '{32'h1234_5678, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 32'h0},
    '{32'hDEAD_BEEF, 1'b0, 32'h0},       // last slot before the wrap
    '{32'h0000_0002, 1'b0, 32'h0},       // pointer back at slot 0
    '{32'hF0F0_F0F0, 1'b0, 32'h0},
    '{32'h0F0F_0F0F, 1'b0, 32'h0}
  };

  // ------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them.
  // ------------------------------------------------------------------
  int burst_left = 0;

  // Offer one item, hold it until taken, then queue the expected median.
  task automatic feed(input logic [DATA_W-1:0] s, input logic known,
                      input logic [DATA_W-1:0] typed_median);
    logic [DATA_W-1:0] predicted;
    if (burst_left == 0) begin
      // Drop valid for a random, nonempty gap, then start a new burst;
      // long bursts give stretches with no sender idling at all.
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid    <= 1'b1;
    sample_time <= s;
    do @(posedge clk); while (in_stall);
    predicted = insert_and_rank(s);
    median_expected_q.push_back(known ? typed_median : predicted);
  endtask

  // Random samples: wide values in four of ten picks, with clusters and repeats so that
  // equal entries sit around the median rank, plus both ends of the range.
  logic [DATA_W-1:0] last_sample  = '0;
  logic [DATA_W-1:0] cluster_base = 32'd100000;

  function automatic logic [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom;
      4, 5: begin
        if ($urandom_range(0, 15) == 0) cluster_base = $urandom;
        s = cluster_base + DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
      end
      6: case ($urandom_range(0, 2))
           0:       s = '0;
           1:       s = '1;
           default: s = 32'd100000;
         endcase
      7: s = $urandom_range(0, 31);
      8: s = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFE0);
      default: s = last_sample;
    endcase
    last_sample = s;
    return s;
  endfunction

  // ------------------------------------------------------------------
  // Receiver: stall on its own pattern, switching at random between no stall,
  // light stall and heavy stall.
  // ------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ------------------------------------------------------------------
  // Checker: compare each taken result with the oldest expected median.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (median_expected_q.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: median %h came out with nothing pending", $realtime, median_value);
        fault_count++;
      end else begin
        logic [DATA_W-1:0] want;
        want = median_expected_q.pop_front();
        if (median_value !== want) begin
          if (fault_count < 10)
            $display("%0t: median_value expected %h got %h", $realtime, want, median_value);
          fault_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Main sequence.
  // ------------------------------------------------------------------
  initial begin
    for (int i = 0; i < WINDOW_SIZE; i++) shadow_window[i] = RESET_TIME;
    shadow_slot = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PROBE_ROWS; r++)
      feed(probe_rows[r].sample, probe_rows[r].known, probe_rows[r].median);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        // Hold off the sender until every pending median has come back.
        in_valid <= 1'b0;
        while (median_expected_q.size() != 0) @(posedge clk);
      end
      feed(pick_sample(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then give the block a full scan's worth of cycles to show any
    // stray result.
    while (median_expected_q.size() != 0) @(posedge clk);
    repeat (WINDOW_SIZE + 8) @(posedge clk);

    if (fault_count == 0) begin
      $display("sliding_window_median_tb passed");
    end else begin
      $display("sliding_window_median_tb failed");
    end
    $finish;
  end

endmodule
